>>> design/rpwt_pkg.sv
// package for the resource pool with wait timeout
// types, codes and sizes shared by the interfaces, controller, datapath and top level
// no dependencies
package rpwt_pkg;

  localparam int NumSlots   = 16;
  localparam int NumClients = 32;
  localparam int OpW        = 2;
  localparam int EventW     = 2;
  localparam int ClientW    = 5;
  localparam int LimitW     = 8;
  localparam int SlotW      = 4;

  localparam logic [OpW-1:0] OpRequest = 2'd0;
  localparam logic [OpW-1:0] OpRelease = 2'd1;
  localparam logic [OpW-1:0] OpTick    = 2'd2;

  localparam logic [EventW-1:0] EvGranted  = 2'd0;
  localparam logic [EventW-1:0] EvParked   = 2'd1;
  localparam logic [EventW-1:0] EvTimeout  = 2'd2;
  localparam logic [EventW-1:0] EvReleased = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [ClientW-1:0] client;
    logic [LimitW-1:0]  wait_limit;
    logic [SlotW-1:0]   resource;
  } in_item_t;

  typedef struct packed {
    logic [EventW-1:0]  event_res;
    logic [ClientW-1:0] client_out;
    logic [SlotW-1:0]   slot;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic load_req;
    logic load_rel;
    logic load_tick;
    logic load_next;
  } dp_cmd_t;

  typedef struct packed {
    logic expire_any;
    logic pend_any;
    logic out_last;
  } dp_sts_t;

endpackage

>>> design/rpwt_if.sv
// valid/ready channel interfaces for the resource pool
// depends on rpwt_pkg
interface rpwt_in_if;
  logic               valid;
  logic               ready;
  rpwt_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rpwt_out_if;
  logic                valid;
  logic                ready;
  rpwt_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/rpwt_ctrl.sv
// controller for the resource pool: sequences accept, timeout reports and result handoff
// depends on rpwt_pkg
module rpwt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  rpwt_pkg::in_item_t in_item_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rpwt_pkg::dp_sts_t  sts_i,
  output rpwt_pkg::dp_cmd_t  cmd_o
);
  import rpwt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_item_i.operation)
            OpRequest: begin
              cmd_o.load_req = 1'b1;
              state_d        = S_OUT;
            end
            OpRelease: begin
              if (in_item_i.resource != '0) begin
                cmd_o.load_rel = 1'b1;
                state_d        = S_OUT;
              end
            end
            OpTick: begin
              cmd_o.load_tick = 1'b1;
              if (sts_i.expire_any) begin
                state_d = S_TICK;
              end
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        cmd_o.load_next = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = sts_i.out_last ? S_IDLE : S_TICK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_tick_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TICK |-> sts_i.pend_any)
    else $error("timeout scan with nothing pending");
  a_pending_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.pend_any |-> state_q != S_IDLE)
    else $error("idle while timeout reports pending");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accepting while a result is held");
`endif

endmodule

>>> design/rpwt_dp.sv
// datapath for the resource pool: slot, waiter and count state, encoders, result register
// depends on rpwt_pkg
module rpwt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpwt_pkg::in_item_t  in_item_i,
  input  rpwt_pkg::dp_cmd_t   cmd_i,
  output rpwt_pkg::dp_sts_t   sts_o,
  output rpwt_pkg::out_item_t out_item_o
);
  import rpwt_pkg::*;

  logic [NumSlots-1:0]   slot_busy_q, slot_busy_d;
  logic [NumClients-1:0] waiting_q, waiting_d;
  logic [NumClients-1:0] pend_q, pend_d;
  logic [LimitW-1:0]     wait_count_q [NumClients];
  logic [LimitW-1:0]     wait_count_d [NumClients];
  out_item_t             out_q, out_d;

  logic [NumClients-1:0] expire;
  logic [NumSlots-1:0]   free_now, free_rel;
  logic [SlotW-1:0]      slot_req, slot_rel;
  logic [ClientW-1:0]    waiter, next_pend;

  // lowest set bit from slot 1 upward, zero when none
  function automatic logic [SlotW-1:0] lowest_slot(input logic [NumSlots-1:0] v);
    logic [SlotW-1:0] r;
    r = '0;
    for (int i = NumSlots - 1; i >= 1; i--) begin
      if (v[i]) r = SlotW'(i);
    end
    return r;
  endfunction

  function automatic logic [ClientW-1:0] lowest_client(input logic [NumClients-1:0] v);
    logic [ClientW-1:0] r;
    r = '0;
    for (int i = NumClients - 1; i >= 0; i--) begin
      if (v[i]) r = ClientW'(i);
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < NumClients; i++) begin
      expire[i] = waiting_q[i] && (wait_count_q[i] == '0);
    end
  end

  assign free_now  = ~slot_busy_q;
  assign free_rel  = free_now | (NumSlots'(1) << in_item_i.resource);
  assign slot_req  = lowest_slot(free_now);
  assign slot_rel  = lowest_slot(free_rel);
  assign waiter    = lowest_client(waiting_q);
  assign next_pend = lowest_client(pend_q);

  always_comb begin
    slot_busy_d  = slot_busy_q;
    waiting_d    = waiting_q;
    pend_d       = pend_q;
    wait_count_d = wait_count_q;
    out_d        = out_q;
    if (cmd_i.load_req) begin
      if (slot_req != '0) begin
        slot_busy_d[slot_req]               = 1'b1;
        waiting_d[in_item_i.client]         = 1'b0;
        wait_count_d[in_item_i.client]      = '0;
        out_d = '{event_res: EvGranted, client_out: in_item_i.client,
                  slot: slot_req, last: 1'b1};
      end else begin
        waiting_d[in_item_i.client]         = 1'b1;
        wait_count_d[in_item_i.client]      = in_item_i.wait_limit;
        out_d = '{event_res: EvParked, client_out: in_item_i.client,
                  slot: '0, last: 1'b1};
      end
    end
    if (cmd_i.load_rel) begin
      slot_busy_d[in_item_i.resource] = 1'b0;
      if (|waiting_q) begin
        waiting_d[waiter]      = 1'b0;
        wait_count_d[waiter]   = '0;
        slot_busy_d[slot_rel]  = 1'b1;
        out_d = '{event_res: EvGranted, client_out: waiter, slot: slot_rel, last: 1'b1};
      end else begin
        out_d = '{event_res: EvReleased, client_out: in_item_i.client,
                  slot: in_item_i.resource, last: 1'b1};
      end
    end
    if (cmd_i.load_tick) begin
      for (int i = 0; i < NumClients; i++) begin
        if (waiting_q[i] && !expire[i]) begin
          wait_count_d[i] = wait_count_q[i] - LimitW'(1);
        end
      end
      waiting_d = waiting_q & ~expire;
      pend_d    = expire;
    end
    if (cmd_i.load_next) begin
      pend_d[next_pend] = 1'b0;
      out_d = '{event_res: EvTimeout, client_out: next_pend, slot: '0,
                last: ((pend_q & ~(NumClients'(1) << next_pend)) == '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_busy_q  <= '0;
      waiting_q    <= '0;
      pend_q       <= '0;
      wait_count_q <= '{default: '0};
    end else begin
      slot_busy_q  <= slot_busy_d;
      waiting_q    <= waiting_d;
      pend_q       <= pend_d;
      wait_count_q <= wait_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.expire_any = |expire;
  assign sts_o.pend_any   = |pend_q;
  assign sts_o.out_last   = out_q.last;
  assign out_item_o       = out_q;

`ifndef ASSERT_OFF
  a_wait_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|waiting_q) |-> (&slot_busy_q[NumSlots-1:1]))
    else $error("client waiting while a slot is free");
  a_slot_zero_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slot_busy_q[0])
    else $error("slot zero allocated");
  a_pend_not_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & waiting_q) == '0)
    else $error("timed out client still waiting");
`endif

endmodule

>>> design/resource_pool_with_wait_timeout.sv
// top level of the resource pool with wait timeout
// depends on rpwt_pkg, rpwt_if, rpwt_ctrl and rpwt_dp
//
//   channel  dir  payload
//   in_i     in   operation, client, wait_limit, resource
//   out_o    out  event_res, client_out, slot, last
//
// request and release: accepted while idle, result held from the next cycle until handoff, then idle again
// tick: stays idle with no expiry, else a scan state and an output state per expired waiter (one report per scan step)
// ignored items (release of slot 0, unused operation) are accepted and give no result
// reset clears all slots, waiters and counts at once; no item is taken while a result is held

module resource_pool_with_wait_timeout (
  input  logic           clk_i,
  input  logic           rst_ni,
  rpwt_in_if.sink        in_i,
  rpwt_out_if.source     out_o
);
  import rpwt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rpwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_item_i   (in_i.payload),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpwt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_i.payload),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_o.payload)
  );

endmodule
